/* design/csps_pkg.sv */
// ----------------------------------------------------------------------------
// csps_pkg: shared types and constants of the clock sync PID servo
// Field widths, register indexes, reset values and unit status struct.
// ----------------------------------------------------------------------------
package csps_pkg;

    // input word fields
    localparam int SEND_W        = 63;
    localparam int MULT_W        = 8;
    localparam int S_TDATA_W     = 136;

    // result word fields
    localparam int DRIFT_W       = 32;
    localparam int STEP_W        = 64;
    localparam int M_TDATA_W     = 96;

    // configuration registers
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 32;
    localparam int DELAY_W       = 32;
    localparam int TPM_W         = 20;
    localparam int BASE_W        = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER_DELAY = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MS   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_PERIOD_MS = 8'd2;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 32'hFFFF_FA24;   // -1500
    localparam logic [TPM_W-1:0]   TPM_RESET   = 20'd38400;
    localparam logic [BASE_W-1:0]  BASE_RESET  = 16'd1000;

    // largest tick rate in normal use; the register itself holds up to 2^20 - 1
    localparam int TPM_MAX       = 1000000;

    // internal datapath widths
    localparam int OFS_W         = 64;   // full offset
    localparam int NARROW_W      = 24;   // offset once bounded by 3 ms
    localparam int PERIOD_W      = BASE_W + MULT_W;
    localparam int PD_DIVIDEND_W = NARROW_W + 16;
    localparam int THR_W         = TPM_W + 2;

    // status of a bit-serial unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

/* design/clock_sync_pid_servo_unit.sv */
// ----------------------------------------------------------------------------
// clock_sync_pid_servo_unit: PID clock servo with millisecond step correction
// Sequence from accept to m_tvalid: the serial offset, then the P and D divides
// (run side by side), then control; a step adds the step divide and its
// hand-off. One word at a time; the next word is taken while the last result
// waits on m_tready.
// Reset (aresetn low, synchronous) restores the registers to their defaults
// and clears the previous offset and the integral.
// ----------------------------------------------------------------------------
module clock_sync_pid_servo_unit
    import csps_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [62:0] master_send_time, [125:63] local_receive_time,
    // [133:126] period_multiplier, [135:134] zero
    input  logic [S_TDATA_W-1:0]   s_tdata,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [31:0] drift_correction, [95:32] step_ms
    output logic [M_TDATA_W-1:0]   m_tdata,
    // [0] stepped
    output logic                   m_tuser,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_OFS  = 4'd1;
    localparam logic [3:0] ST_MAG  = 4'd2;
    localparam logic [3:0] ST_CMP  = 4'd3;
    localparam logic [3:0] ST_SDIV = 4'd4;
    localparam logic [3:0] ST_PREP = 4'd5;
    localparam logic [3:0] ST_PDIV = 4'd6;
    localparam logic [3:0] ST_SUM1 = 4'd7;
    localparam logic [3:0] ST_SUM2 = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    localparam int PD_W = PD_DIVIDEND_W + 2;
    localparam logic signed [OFS_W-1:0] W_MAX = 64'sd2147483647;
    localparam logic signed [OFS_W-1:0] W_MIN = -64'sd2147483648;
    localparam int PREV_BOUND = 3 * ((1 << TPM_W) - 1);

    logic [3:0] state_reg, state_next;

    // configuration registers
    logic [DELAY_W-1:0] delay_reg;
    logic [TPM_W-1:0]   tpm_reg;
    logic [BASE_W-1:0]  base_reg;

    // per-word working registers
    logic [TPM_W-1:0]           tpm_eff_reg;
    logic [PERIOD_W-1:0]        period_reg;
    logic [OFS_W-1:0]           offset_reg;
    logic [OFS_W-1:0]           mag_reg;
    logic                       ofs_neg_reg;
    logic signed [NARROW_W-1:0] offs_reg;
    logic                       p_neg_reg;
    logic                       d_neg_reg;
    logic signed [PD_W-1:0]     pd_reg;
    logic                       stepped_reg;
    logic [STEP_W-1:0]          step_ms_reg;
    logic [DRIFT_W-1:0]         w_reg;

    // servo state
    logic signed [NARROW_W-1:0] prev_reg;
    logic signed [OFS_W-1:0]    integral_reg;

    // result word
    logic                m_tvalid_reg;
    logic [DRIFT_W-1:0]  drift_out_reg;
    logic [STEP_W-1:0]   step_out_reg;
    logic                stepped_out_reg;

    logic s_accept;
    logic out_free;

    // serial units
    unit_status_t ofs_status, sdiv_status, pdiv_status, ddiv_status;
    logic [OFS_W-1:0] ofs_value;
    logic [OFS_W-1:0] sdiv_q;
    logic [TPM_W-1:0] sdiv_r;
    logic [PD_DIVIDEND_W-1:0] pdiv_q, ddiv_q;
    logic [PERIOD_W-1:0] pdiv_r, ddiv_r;
    logic sdiv_start, pdiv_start;

    // combinational helpers
    logic [MULT_W-1:0]          mult_eff;
    logic [BASE_W-1:0]          base_eff;
    logic [THR_W-1:0]           thr;
    logic                       stepped_now;
    logic [STEP_W-1:0]          ms_val;
    logic [NARROW_W-1:0]        rem_val;
    logic signed [NARROW_W:0]   diff;
    logic [NARROW_W-1:0]        offs_abs;
    logic [NARROW_W:0]          diff_neg;
    logic [NARROW_W-1:0]        diff_abs;
    logic [PD_DIVIDEND_W-1:0]   p_dividend, d_dividend;
    logic signed [PD_DIVIDEND_W:0] p_s, d_s;
    logic signed [PD_W-1:0]     pd_sum;
    logic signed [OFS_W:0]      int_sum;
    logic signed [OFS_W-1:0]    int_sat;
    logic signed [OFS_W-1:0]    w64;
    logic [DRIFT_W-1:0]         w_sat;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = ~m_tvalid_reg | m_tready;

    // serial offset former
    csps_offset u_offset (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_accept),
        .send_time (s_tdata[SEND_W-1:0]),
        .recv_time (s_tdata[2*SEND_W-1:SEND_W]),
        .delay     (delay_reg),
        .status    (ofs_status),
        .offset    (ofs_value)
    );

    // step divide: |offset| / ticks_per_ms
    csps_div #(
        .DIVIDEND_W (OFS_W),
        .DIVISOR_W  (TPM_W)
    ) u_step_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (sdiv_start),
        .dividend  (mag_reg),
        .divisor   (tpm_eff_reg),
        .status    (sdiv_status),
        .quotient  (sdiv_q),
        .remainder (sdiv_r)
    );

    // proportional term divide
    csps_div #(
        .DIVIDEND_W (PD_DIVIDEND_W),
        .DIVISOR_W  (PERIOD_W)
    ) u_p_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (pdiv_start),
        .dividend  (p_dividend),
        .divisor   (period_reg),
        .status    (pdiv_status),
        .quotient  (pdiv_q),
        .remainder (pdiv_r)
    );

    // derivative term divide
    csps_div #(
        .DIVIDEND_W (PD_DIVIDEND_W),
        .DIVISOR_W  (PERIOD_W)
    ) u_d_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (pdiv_start),
        .dividend  (d_dividend),
        .divisor   (period_reg),
        .status    (ddiv_status),
        .quotient  (ddiv_q),
        .remainder (ddiv_r)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_accept) state_next = ST_OFS;
            ST_OFS:  if (ofs_status.done) state_next = ST_MAG;
            ST_MAG:  state_next = ST_CMP;
            ST_CMP:  state_next = stepped_now ? ST_SDIV : ST_PREP;
            ST_SDIV: if (sdiv_status.done) state_next = ST_PREP;
            ST_PREP: state_next = ST_PDIV;
            ST_PDIV: if (pdiv_status.done && ddiv_status.done) state_next = ST_SUM1;
            ST_SUM1: state_next = ST_SUM2;
            ST_SUM2: state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // operand preparation and arithmetic
    always_comb begin
        mult_eff = (s_tdata[2*SEND_W+MULT_W-1:2*SEND_W] == '0)
                 ? MULT_W'(1) : s_tdata[2*SEND_W+MULT_W-1:2*SEND_W];
        base_eff = (base_reg == '0) ? BASE_W'(1) : base_reg;

        // threshold 3 ms = tpm*2 + tpm
        thr         = {tpm_eff_reg, 1'b0} + {2'b00, tpm_eff_reg};
        stepped_now = (mag_reg > {{(OFS_W-THR_W){1'b0}}, thr});
        sdiv_start  = (state_reg == ST_CMP) && stepped_now;
        pdiv_start  = (state_reg == ST_PREP);

        // truncating signed step and remainder
        ms_val  = ofs_neg_reg ? (STEP_W'(0) - sdiv_q) : sdiv_q;
        rem_val = ofs_neg_reg ? (NARROW_W'(0) - {4'b0000, sdiv_r}) : {4'b0000, sdiv_r};

        // dividend magnitudes, scaled by 2^16
        diff       = {offs_reg[NARROW_W-1], offs_reg} - {prev_reg[NARROW_W-1], prev_reg};
        offs_abs   = offs_reg[NARROW_W-1] ? (NARROW_W'(0) - offs_reg) : offs_reg;
        diff_neg   = (NARROW_W+1)'(0) - diff;
        diff_abs   = diff[NARROW_W] ? diff_neg[NARROW_W-1:0] : diff[NARROW_W-1:0];
        p_dividend = {offs_abs, 16'h0000};
        d_dividend = {diff_abs, 16'h0000};

        // signed quotients, floor shifts
        p_s    = p_neg_reg ? ((PD_DIVIDEND_W+1)'(0) - {1'b0, pdiv_q}) : {1'b0, pdiv_q};
        d_s    = d_neg_reg ? ((PD_DIVIDEND_W+1)'(0) - {1'b0, ddiv_q}) : {1'b0, ddiv_q};
        pd_sum = PD_W'(p_s >>> 1) + PD_W'(d_s >>> 3);

        // saturating integral update
        int_sum = {integral_reg[OFS_W-1], integral_reg}
                + {{(OFS_W+1-NARROW_W){offs_reg[NARROW_W-1]}}, offs_reg};
        if (int_sum[OFS_W] != int_sum[OFS_W-1]) begin
            int_sat = int_sum[OFS_W] ? {1'b1, {(OFS_W-1){1'b0}}}
                                     : {1'b0, {(OFS_W-1){1'b1}}};
        end else begin
            int_sat = int_sum[OFS_W-1:0];
        end

        // output word, clamped to 32 bits
        w64 = OFS_W'(pd_reg) + (integral_reg >>> 4);
        if (w64 > W_MAX) begin
            w_sat = W_MAX[DRIFT_W-1:0];
        end else if (w64 < W_MIN) begin
            w_sat = W_MIN[DRIFT_W-1:0];
        end else begin
            w_sat = w64[DRIFT_W-1:0];
        end
    end

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= DELAY_RESET;
            tpm_reg   <= TPM_RESET;
            base_reg  <= BASE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_TRANSFER_DELAY: delay_reg <= cfg_data[DELAY_W-1:0];
                CFG_TICKS_PER_MS:   tpm_reg   <= cfg_data[TPM_W-1:0];
                CFG_BASE_PERIOD_MS: base_reg  <= cfg_data[BASE_W-1:0];
                default: ;
            endcase
        end
    end

    // control state and servo state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            prev_reg     <= '0;
            integral_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // result valid: set on hand-off to the output, cleared when taken
            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_SDIV: begin
                    // step taken: restart the loop from the remainder
                    if (sdiv_status.done) begin
                        integral_reg <= '0;
                        prev_reg     <= rem_val;
                    end
                end
                ST_SUM1: integral_reg <= int_sat;
                ST_SUM2: prev_reg     <= offs_reg;
                default: ;
            endcase
        end
    end

    // working datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    tpm_eff_reg <= (tpm_reg == '0) ? TPM_W'(1) : tpm_reg;
                    period_reg  <= base_eff * mult_eff;
                end
            end
            ST_OFS: begin
                if (ofs_status.done) begin
                    offset_reg <= ofs_value;
                end
            end
            ST_MAG: begin
                ofs_neg_reg <= offset_reg[OFS_W-1];
                mag_reg     <= offset_reg[OFS_W-1] ? (OFS_W'(0) - offset_reg) : offset_reg;
            end
            ST_CMP: begin
                stepped_reg <= stepped_now;
                step_ms_reg <= '0;
                offs_reg    <= offset_reg[NARROW_W-1:0];
            end
            ST_SDIV: begin
                if (sdiv_status.done) begin
                    step_ms_reg <= ms_val;
                    offs_reg    <= rem_val;
                end
            end
            ST_PREP: begin
                p_neg_reg <= offs_reg[NARROW_W-1];
                d_neg_reg <= diff[NARROW_W];
            end
            ST_SUM1: pd_reg <= pd_sum;
            ST_SUM2: w_reg  <= w_sat;
            ST_OUT: begin
                if (out_free) begin
                    drift_out_reg   <= w_reg;
                    step_out_reg    <= step_ms_reg;
                    stepped_out_reg <= stepped_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {step_out_reg, drift_out_reg};
    assign m_tuser  = stepped_out_reg;

    // a serial unit finishes only while the sequencer waits for it
    ap_ofs_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ofs_status.done |-> state_reg == ST_OFS)
        else $error("offset unit finished outside its wait state");

    ap_sdiv_done: assert property (@(posedge aclk) disable iff (!aresetn)
        sdiv_status.done |-> state_reg == ST_SDIV)
        else $error("step divider finished outside its wait state");

    // P and D divides run in lockstep
    ap_pd_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        pdiv_status.done == ddiv_status.done)
        else $error("P and D dividers out of step");

    // narrowed previous offset stays within the 3 ms bound
    ap_prev_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (prev_reg <= PREV_BOUND) && (prev_reg >= -PREV_BOUND))
        else $error("previous offset beyond step threshold");

    // a word without a step reports zero milliseconds
    ap_no_step_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[M_TDATA_W-1:DRIFT_W] == '0))
        else $error("step_ms nonzero without a step");

endmodule

/* design/csps_div.sv */
// ----------------------------------------------------------------------------
// csps_div: bit-serial unsigned restoring divider
// Dividend shifts out MSB first, one quotient bit enters per cycle.
// ----------------------------------------------------------------------------
module csps_div
    import csps_pkg::*;
#(
    parameter int DIVIDEND_W = 64,
    parameter int DIVISOR_W  = 20
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output unit_status_t          status,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [DIVISOR_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dsr_reg;

    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W+1:0]  trial;
    logic                  q_bit;

    // one trial subtraction per cycle
    always_comb begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
        trial     = {1'b0, rem_shift} - {2'b00, dsr_reg};
        q_bit     = ~trial[DIVISOR_W+1];
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], q_bit};
            rem_reg <= q_bit ? trial[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
        end
    end

    assign status    = '{busy: busy_reg, done: done_reg};
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* design/csps_offset.sv */
// ----------------------------------------------------------------------------
// csps_offset: bit-serial offset former
// send - receive + delay, LSB first, saturated to 64 bits.
// ----------------------------------------------------------------------------
module csps_offset
    import csps_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [SEND_W-1:0]   send_time,
    input  logic [SEND_W-1:0]   recv_time,
    input  logic [DELAY_W-1:0]  delay,
    output unit_status_t        status,
    output logic [OFS_W-1:0]    offset
);

    localparam int STEPS = OFS_W + 1;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [SEND_W-1:0]  send_sh_reg;
    logic [SEND_W-1:0]  recv_sh_reg;
    logic [DELAY_W-1:0] dly_sh_reg;
    logic               c1_reg;
    logic               c2_reg;
    logic [STEPS-1:0]   acc_reg;

    logic a_bit, b_bit, d_bit, t_bit, u_bit, c1_next, c2_next;

    // two chained full adders: subtract, then add delay
    always_comb begin
        a_bit   = send_sh_reg[0];
        b_bit   = ~recv_sh_reg[0];
        d_bit   = dly_sh_reg[0];
        t_bit   = a_bit ^ b_bit ^ c1_reg;
        c1_next = (a_bit & b_bit) | (a_bit & c1_reg) | (b_bit & c1_reg);
        u_bit   = t_bit ^ d_bit ^ c2_reg;
        c2_next = (t_bit & d_bit) | (t_bit & c2_reg) | (d_bit & c2_reg);
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operand shifters and result shifter
    always_ff @(posedge aclk) begin
        if (start) begin
            send_sh_reg <= send_time;
            recv_sh_reg <= recv_time;
            dly_sh_reg  <= delay;
            c1_reg      <= 1'b1;
            c2_reg      <= 1'b0;
        end else if (busy_reg) begin
            send_sh_reg <= {1'b0, send_sh_reg[SEND_W-1:1]};
            recv_sh_reg <= {1'b0, recv_sh_reg[SEND_W-1:1]};
            dly_sh_reg  <= {dly_sh_reg[DELAY_W-1], dly_sh_reg[DELAY_W-1:1]};
            c1_reg      <= c1_next;
            c2_reg      <= c2_next;
            acc_reg     <= {u_bit, acc_reg[STEPS-1:1]};
        end
    end

    // clamp to the signed 64-bit range
    always_comb begin
        if (acc_reg[STEPS-1] != acc_reg[OFS_W-1]) begin
            offset = acc_reg[STEPS-1] ? {1'b1, {(OFS_W-1){1'b0}}}
                                      : {1'b0, {(OFS_W-1){1'b1}}};
        end else begin
            offset = acc_reg[OFS_W-1:0];
        end
    end

    assign status = '{busy: busy_reg, done: done_reg};

endmodule
